### design/grg_pkg.sv
// Package with payload types and constants for the Givens rotation generator.
`default_nettype none
package grg_pkg;

    localparam int unsigned MagW   = 32;
    localparam int unsigned SumW   = 64;
    localparam int unsigned RootW  = 32;
    localparam int unsigned QuoW   = 31;

    localparam logic [1:0] AxisX    = 2'd0;
    localparam logic [1:0] AxisY    = 2'd1;
    localparam logic [1:0] AxisZ    = 2'd2;
    localparam logic [1:0] AxisNone = 2'd3;

    localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] elem_21;
        logic signed [31:0] elem_22;
        logic signed [31:0] elem_31;
        logic signed [31:0] elem_32;
        logic signed [31:0] elem_33;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rot_00;
        logic signed [31:0] rot_01;
        logic signed [31:0] rot_02;
        logic signed [31:0] rot_10;
        logic signed [31:0] rot_11;
        logic signed [31:0] rot_12;
        logic signed [31:0] rot_20;
        logic signed [31:0] rot_21;
        logic signed [31:0] rot_22;
        logic               zero_norm;
    } t_out_item;

    // Side information that travels with an item along the cell chains.
    typedef struct packed {
        logic [1:0] axis;
        logic       neg_u;
        logic       neg_v;
        logic       zero;
    } t_tag;

endpackage : grg_pkg
`default_nettype wire

### design/grg_sqrt_cell.sv
// One stage of the pipelined restoring square root: settles one result bit.
`default_nettype none
module grg_sqrt_cell #(
    parameter int unsigned Step = 31
) (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire [grg_pkg::SumW-1:0]   i_rem,
    input  wire [grg_pkg::RootW-1:0]  i_root,
    input  wire [grg_pkg::MagW-1:0]   i_u,
    input  wire [grg_pkg::MagW-1:0]   i_v,
    input  grg_pkg::t_tag             i_tag,
    output logic [grg_pkg::SumW-1:0]  o_rem,
    output logic [grg_pkg::RootW-1:0] o_root,
    output logic [grg_pkg::MagW-1:0]  o_u,
    output logic [grg_pkg::MagW-1:0]  o_v,
    output grg_pkg::t_tag             o_tag
);
    import grg_pkg::*;

    logic [SumW+1:0] trial;
    logic [SumW+1:0] rem_w;

    // Trial value (2*root + 1) placed at this stage's bit pair.
    always_comb begin
        rem_w = {2'b00, i_rem};
        trial = ({{(SumW-RootW+2){1'b0}}, i_root} << (Step + 1))
              | ({{(SumW+1){1'b0}}, 1'b1} << (2 * Step));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (rem_w >= trial) begin
                o_rem  <= SumW'(rem_w - trial);
                o_root <= i_root | (RootW'(1) << Step);
            end else begin
                o_rem  <= i_rem;
                o_root <= i_root;
            end
            o_u   <= i_u;
            o_v   <= i_v;
            o_tag <= i_tag;
        end
    end

endmodule : grg_sqrt_cell
`default_nettype wire

### design/grg_div_cell.sv
// One stage of the pipelined restoring dividers: one quotient bit of c and of s.
`default_nettype none
module grg_div_cell #(
    parameter int unsigned Step = 30
) (
    input  wire                       i_clk,
    input  wire                       i_en,
    input  wire [grg_pkg::RootW:0]    i_rem_c,
    input  wire [grg_pkg::RootW:0]    i_rem_s,
    input  wire [grg_pkg::QuoW-1:0]   i_q_c,
    input  wire [grg_pkg::QuoW-1:0]   i_q_s,
    input  wire [grg_pkg::RootW-1:0]  i_den,
    input  grg_pkg::t_tag             i_tag,
    output logic [grg_pkg::RootW:0]   o_rem_c,
    output logic [grg_pkg::RootW:0]   o_rem_s,
    output logic [grg_pkg::QuoW-1:0]  o_q_c,
    output logic [grg_pkg::QuoW-1:0]  o_q_s,
    output logic [grg_pkg::RootW-1:0] o_den,
    output grg_pkg::t_tag             o_tag
);
    import grg_pkg::*;

    logic [RootW+1:0] sh_c, sh_s, den_w;

    // Numerator bits below 2^30 are zero, so only a zero is shifted in.
    always_comb begin
        sh_c  = {i_rem_c, 1'b0};
        sh_s  = {i_rem_s, 1'b0};
        den_w = {2'b00, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sh_c >= den_w) begin
                o_rem_c <= (RootW+1)'(sh_c - den_w);
                o_q_c   <= i_q_c | (QuoW'(1) << Step);
            end else begin
                o_rem_c <= (RootW+1)'(sh_c);
                o_q_c   <= i_q_c;
            end
            if (sh_s >= den_w) begin
                o_rem_s <= (RootW+1)'(sh_s - den_w);
                o_q_s   <= i_q_s | (QuoW'(1) << Step);
            end else begin
                o_rem_s <= (RootW+1)'(sh_s);
                o_q_s   <= i_q_s;
            end
            o_den <= i_den;
            o_tag <= i_tag;
        end
    end

endmodule : grg_div_cell
`default_nettype wire

### design/givens_rotation_generator_top.sv
// Top level of the Givens rotation generator: input stage, cell chains, output.
//
// Use: a request on the input channel carries an axis code and five Q16.16
// matrix entries; one result request carries nine Q2.30 rotation entries and
// the zero_norm flag. Both channels use valid and stall.
// From acceptance to result valid a request passes the select and normalise
// register, the squares register, the sum register, 32 square-root cells,
// 30 divider cells (one quotient bit each, the top bit being settled before
// them), one cell for the rounding bit and the output register.
// Throughput is one request per cycle. The whole chain advances together
// and holds only when the output register is full and stalled, so stall on
// the output reaches the input in the same cycle.
// Reset clears the valid bits of every stage; data registers are not reset.
// An unused axis code gives the identity with zero_norm low; two zero
// entries give the identity with zero_norm high.
`default_nettype none
module givens_rotation_generator_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  grg_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  wire                  i_stall,
    output grg_pkg::t_out_item   o_data
);
    import grg_pkg::*;

    localparam int unsigned SqN  = RootW;      // square-root cells
    localparam int unsigned DivN = QuoW;       // divider cells
    localparam int unsigned Lat  = 3 + SqN + DivN;

    logic adv;
    logic [Lat-1:0] r_vld;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (adv) begin
            r_vld   <= {r_vld[Lat-2:0], i_valid};
            o_valid <= r_vld[Lat-1];
        end
    end

    // Stage 0: select operands, magnitudes and normalising shift.
    logic signed [31:0] u_s, v_s;
    logic [MagW-1:0]    au, av, mx;
    logic [4:0]         nsh;
    logic [MagW-1:0]    r_u0, r_v0;
    t_tag               r_t0, tag0;

    always_comb begin
        unique case (i_data.axis)
            AxisZ: begin
                u_s = i_data.elem_22;
                v_s = i_data.elem_21;
            end
            AxisY: begin
                u_s = i_data.elem_33;
                v_s = i_data.elem_31;
            end
            default: begin
                u_s = i_data.elem_33;
                v_s = i_data.elem_32;
            end
        endcase
        au = u_s[31] ? MagW'(-u_s) : MagW'(u_s);
        av = v_s[31] ? MagW'(-v_s) : MagW'(v_s);
        mx = (au > av) ? au : av;
        nsh = '0;
        // Leading zeros of bits 30:0, at most 30; zero if bit 31 is set or mx is zero.
        for (int k = 29; k >= 0; k--) begin
            if (mx[k] && nsh == 5'd0 && mx[31:30] == 2'b00 && (mx >> (k + 1)) == '0)
                nsh = 5'(30 - k);
        end
        tag0.axis  = i_data.axis;
        tag0.neg_u = u_s[31];
        tag0.neg_v = v_s[31];
        tag0.zero  = (mx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u0 <= au << nsh;
            r_v0 <= av << nsh;
            r_t0 <= tag0;
        end
    end

    // Stage 1: squares. Stage 2: sum.
    logic [SumW-1:0] r_uu, r_vv, r_sum;
    logic [MagW-1:0] r_u1, r_v1, r_u2, r_v2;
    t_tag            r_t1, r_t2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_uu  <= r_u0 * r_u0;
            r_vv  <= r_v0 * r_v0;
            r_u1  <= r_u0;
            r_v1  <= r_v0;
            r_t1  <= r_t0;
            r_sum <= r_uu + r_vv;
            r_u2  <= r_u1;
            r_v2  <= r_v1;
            r_t2  <= r_t1;
        end
    end

    // Square-root chain.
    logic [SumW-1:0]  sq_rem  [SqN+1];
    logic [RootW-1:0] sq_root [SqN+1];
    logic [MagW-1:0]  sq_u    [SqN+1];
    logic [MagW-1:0]  sq_v    [SqN+1];
    t_tag             sq_tag  [SqN+1];

    assign sq_rem[0]  = r_sum;
    assign sq_root[0] = '0;
    assign sq_u[0]    = r_u2;
    assign sq_v[0]    = r_v2;
    assign sq_tag[0]  = r_t2;

    for (genvar g = 0; g < SqN; g++) begin : g_sq
        grg_sqrt_cell #(.Step(SqN - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_u    (sq_u[g]),
            .i_v    (sq_v[g]),
            .i_tag  (sq_tag[g]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_u    (sq_u[g+1]),
            .o_v    (sq_v[g+1]),
            .o_tag  (sq_tag[g+1])
        );
    end

    // Divider chain: quotient bits 30..0 of (U*2^30)/R. U < 2R always, so
    // the start remainder is U itself with bit 30 of the quotient next.
    logic [RootW:0]   dv_rc  [DivN+1];
    logic [RootW:0]   dv_rs  [DivN+1];
    logic [QuoW-1:0]  dv_qc  [DivN+1];
    logic [QuoW-1:0]  dv_qs  [DivN+1];
    logic [RootW-1:0] dv_den [DivN+1];
    t_tag             dv_tag [DivN+1];
    logic             pre_c, pre_s;
    logic [RootW:0]   st_rc, st_rs;
    logic [RootW-1:0] den_s;

    // Handle the top bit (2^30 weight) before the chain: U >= R gives q = 2^30.
    always_comb begin
        den_s = (sq_root[SqN] == '0) ? RootW'(1) : sq_root[SqN];
        pre_c = ({1'b0, sq_u[SqN]} >= {1'b0, den_s});
        pre_s = ({1'b0, sq_v[SqN]} >= {1'b0, den_s});
        st_rc = pre_c ? (RootW+1)'(sq_u[SqN] - den_s) : {1'b0, sq_u[SqN]};
        st_rs = pre_s ? (RootW+1)'(sq_v[SqN] - den_s) : {1'b0, sq_v[SqN]};
    end

    assign dv_rc[0]  = st_rc;
    assign dv_rs[0]  = st_rs;
    assign dv_qc[0]  = {pre_c, {(QuoW-1){1'b0}}};
    assign dv_qs[0]  = {pre_s, {(QuoW-1){1'b0}}};
    assign dv_den[0] = den_s;
    assign dv_tag[0] = sq_tag[SqN];

    // Cells produce quotient bits 29..0 and then one extra round bit in
    // bit position -1, which the last cell stores as bit 0 of its remainder output.
    for (genvar g = 0; g < DivN; g++) begin : g_dv
        if (g < DivN - 1) begin : g_q
            grg_div_cell #(.Step(QuoW - 2 - g)) u_cell (
                .i_clk   (i_clk),
                .i_en    (adv),
                .i_rem_c (dv_rc[g]),
                .i_rem_s (dv_rs[g]),
                .i_q_c   (dv_qc[g]),
                .i_q_s   (dv_qs[g]),
                .i_den   (dv_den[g]),
                .i_tag   (dv_tag[g]),
                .o_rem_c (dv_rc[g+1]),
                .o_rem_s (dv_rs[g+1]),
                .o_q_c   (dv_qc[g+1]),
                .o_q_s   (dv_qs[g+1]),
                .o_den   (dv_den[g+1]),
                .o_tag   (dv_tag[g+1])
            );
        end else begin : g_r
            // Round cell: 2*rem >= den gives round-half-up, equal to adding
            // floor(R/2) before the floor division.
            logic r_rc, r_rs;
            logic [QuoW-1:0] r_qc, r_qs;
            logic [RootW-1:0] r_dn;
            t_tag r_tg;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rc <= ({dv_rc[g], 1'b0} >= {2'b00, dv_den[g]});
                    r_rs <= ({dv_rs[g], 1'b0} >= {2'b00, dv_den[g]});
                    r_qc <= dv_qc[g];
                    r_qs <= dv_qs[g];
                    r_dn <= dv_den[g];
                    r_tg <= dv_tag[g];
                end
            end
            assign dv_rc[g+1]  = {{RootW{1'b0}}, r_rc};
            assign dv_rs[g+1]  = {{RootW{1'b0}}, r_rs};
            assign dv_qc[g+1]  = r_qc;
            assign dv_qs[g+1]  = r_qs;
            assign dv_den[g+1] = r_dn;
            assign dv_tag[g+1] = r_tg;
        end
    end

    // Rounding, saturation, sign and placement in the output register.
    logic [QuoW:0]       cm, sm;
    logic signed [31:0]  c, s;
    t_tag                tg;
    t_out_item           res;

    always_comb begin
        tg = dv_tag[DivN];
        cm = {1'b0, dv_qc[DivN]} + (QuoW+1)'(dv_rc[DivN][0]);
        sm = {1'b0, dv_qs[DivN]} + (QuoW+1)'(dv_rs[DivN][0]);
        if (cm > (QuoW+1)'(OneQ30)) cm = (QuoW+1)'(OneQ30);
        if (sm > (QuoW+1)'(OneQ30)) sm = (QuoW+1)'(OneQ30);
        s = tg.neg_v ? -32'(sm) : 32'(sm);
        if (tg.axis == AxisY)
            c = tg.neg_u ? -32'(cm) : 32'(cm);
        else
            c = (!tg.neg_u && cm != '0) ? -32'(cm) : 32'(cm);
        res = '0;
        res.rot_00 = OneQ30;
        res.rot_11 = OneQ30;
        res.rot_22 = OneQ30;
        if (tg.zero && tg.axis != AxisNone) begin
            res.zero_norm = 1'b1;
        end else begin
            unique case (tg.axis)
                AxisX: begin
                    res.rot_11 = c; res.rot_12 = -s;
                    res.rot_21 = s; res.rot_22 = c;
                end
                AxisY: begin
                    res.rot_00 = c; res.rot_02 = s;
                    res.rot_20 = -s; res.rot_22 = c;
                end
                AxisZ: begin
                    res.rot_00 = c; res.rot_01 = -s;
                    res.rot_10 = s; res.rot_11 = c;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) o_data <= res;
    end

endmodule : givens_rotation_generator_top
`default_nettype wire

### design/grg_checker.sv
// Port-level checker for the Givens rotation generator, bound to the top level.
`default_nettype none
module grg_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_valid,
    input wire                o_stall,
    input wire                o_valid,
    input wire                i_stall,
    input grg_pkg::t_out_item o_data
);
    import grg_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid)
        else $error("request withdrawn while stalled");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.zero_norm |-> o_data.rot_00 == OneQ30 &&
        o_data.rot_11 == OneQ30 && o_data.rot_22 == OneQ30 && o_data.rot_01 == 0)
        else $error("zero norm without identity");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall with empty output");

endmodule : grg_checker

bind givens_rotation_generator_top grg_checker u_grg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the Givens rotation generator with a rotation predictor.
`default_nettype none
module tb_top;
    import grg_pkg::*;

    localparam int unsigned DirectedCount = 24;
    localparam int unsigned RandomCount   = 930;
    localparam int unsigned TailCalm      = 120;
    localparam int unsigned PipeDepth     = 67;
    localparam int unsigned WatchLimit    = 4000;

    class rotation_scoreboard;
        t_out_item pending_rots[$];
        int unsigned mismatch_count;

        function logic [31:0] scaled_ratio(logic [63:0] num, logic [63:0] root);
            logic [127:0] quo;
            quo = (({64'd0, num} << 30) + {64'd0, root >> 1}) / {64'd0, root};
            if (quo > 128'h4000_0000) quo = 128'h4000_0000;
            return quo[31:0];
        endfunction

        function logic [63:0] root_floor(logic [63:0] sq);
            logic [63:0] acc;
            logic [63:0] probe;
            acc = 0;
            for (int b = 31; b >= 0; b--) begin
                probe = acc | (64'd1 << b);
                if ({64'd0, probe} * {64'd0, probe} <= {64'd0, sq}) acc = probe;
            end
            return acc;
        endfunction

        function t_out_item rotation_for(t_in_item req);
            t_out_item rot;
            logic signed [31:0] num_u, num_v;
            logic [63:0] mag_u, mag_v, top, r;
            logic signed [31:0] c, s;
            int n;
            rot = '0;
            rot.rot_00 = OneQ30;
            rot.rot_11 = OneQ30;
            rot.rot_22 = OneQ30;
            if (req.axis == AxisX || req.axis == AxisY || req.axis == AxisZ) begin
                if (req.axis == AxisZ) begin
                    num_u = req.elem_22;
                    num_v = req.elem_21;
                end else begin
                    num_u = req.elem_33;
                    num_v = (req.axis == AxisX) ? req.elem_32 : req.elem_31;
                end
                mag_u = num_u < 0 ? -64'(num_u) : 64'(num_u);
                mag_v = num_v < 0 ? -64'(num_v) : 64'(num_v);
                if (mag_u == 0 && mag_v == 0) begin
                    rot.zero_norm = 1'b1;
                end else begin
                    top = mag_u > mag_v ? mag_u : mag_v;
                    n = 0;
                    while (n < 30 && (top << n) < 64'h4000_0000) n++;
                    mag_u = mag_u << n;
                    mag_v = mag_v << n;
                    r = root_floor(mag_u * mag_u + mag_v * mag_v);
                    c = scaled_ratio(mag_u, r);
                    s = scaled_ratio(mag_v, r);
                    if (num_v < 0) s = -s;
                    if (req.axis == AxisY) begin
                        if (num_u < 0) c = -c;
                        rot.rot_00 = c;
                        rot.rot_02 = s;
                        rot.rot_20 = -s;
                        rot.rot_22 = c;
                    end else begin
                        if (num_u > 0) c = -c;
                        if (req.axis == AxisX) begin
                            rot.rot_11 = c;
                            rot.rot_12 = -s;
                            rot.rot_21 = s;
                            rot.rot_22 = c;
                        end else begin
                            rot.rot_00 = c;
                            rot.rot_01 = -s;
                            rot.rot_10 = s;
                            rot.rot_11 = c;
                        end
                    end
                end
            end
            return rot;
        endfunction

        function void note_request(t_in_item req);
            pending_rots.push_back(rotation_for(req));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_rots.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_rots.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    rotation_scoreboard rot_board = new();
    int unsigned idle_cycles = 0;
    bit          calm_phase = 1'b0;
    bit          long_hold = 1'b0;

    always #1 i_clk = ~i_clk;

    givens_rotation_generator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    function automatic logic [31:0] pick_entry();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return $urandom_range(0, 3) - 1;
            4: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(t_in_item req);
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        rot_board.note_request(req);
    endtask

    task automatic sender_gap();
        if (!calm_phase && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (rot_board.pending_rots.size() != 0) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, one long hold to fill the chain.
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (3 * PipeDepth) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) rot_board.check_result(o_data);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_in_item req;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each axis with extreme, zero and one-sided entries, plus the unused code.
        for (int k = 0; k < DirectedCount; k++) begin
            req.axis    = 2'(k % 4);
            req.elem_21 = (k < 4) ? 32'h0 : (k < 8) ? 32'h8000_0000 :
                          (k < 12) ? 32'h7fff_ffff : (k < 16) ? 32'hffff_ffff : pick_entry();
            req.elem_22 = (k < 4) ? 32'h0 : (k < 8) ? 32'h8000_0000 :
                          (k < 12) ? 32'h0 : (k < 16) ? 32'h1 : pick_entry();
            req.elem_31 = req.elem_21;
            req.elem_32 = req.elem_21;
            req.elem_33 = req.elem_22;
            send_request(req);
        end
        wait_drained();

        for (int k = 0; k < RandomCount; k++) begin
            if (k == 200) long_hold = 1'b1;
            if (k == 500) wait_drained();
            if (k == RandomCount - TailCalm) calm_phase = 1'b1;
            req.axis    = ($urandom_range(0, 15) == 0) ? AxisNone : 2'($urandom_range(0, 2));
            req.elem_21 = pick_entry();
            req.elem_22 = pick_entry();
            req.elem_31 = pick_entry();
            req.elem_32 = pick_entry();
            req.elem_33 = pick_entry();
            send_request(req);
            sender_gap();
        end
        wait_drained();
        repeat (PipeDepth + 10) @(posedge i_clk);

        if (rot_board.mismatch_count == 0 && rot_board.pending_rots.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
